// ----- rtl/sfpa_pkg.sv -----
// Package for the saturating fixed-point ALU: opcodes, saturation, shift,
// normalize and divide-step helpers. Depends on nothing.
package sfpa_pkg;

  localparam logic [4:0] OP_ADD       = 5'd0;
  localparam logic [4:0] OP_SUB       = 5'd1;
  localparam logic [4:0] OP_MULT      = 5'd2;
  localparam logic [4:0] OP_MULT_R    = 5'd3;
  localparam logic [4:0] OP_ABS       = 5'd4;
  localparam logic [4:0] OP_NEGATE    = 5'd5;
  localparam logic [4:0] OP_SHL       = 5'd6;
  localparam logic [4:0] OP_SHR       = 5'd7;
  localparam logic [4:0] OP_EXTRACT_H = 5'd8;
  localparam logic [4:0] OP_EXTRACT_L = 5'd9;
  localparam logic [4:0] OP_DEPOSIT_H = 5'd10;
  localparam logic [4:0] OP_DEPOSIT_L = 5'd11;
  localparam logic [4:0] OP_L_ADD     = 5'd12;
  localparam logic [4:0] OP_L_SUB     = 5'd13;
  localparam logic [4:0] OP_L_MAC     = 5'd14;
  localparam logic [4:0] OP_L_SHL     = 5'd15;
  localparam logic [4:0] OP_L_SHR     = 5'd16;
  localparam logic [4:0] OP_NORM_S    = 5'd17;
  localparam logic [4:0] OP_NORM_L    = 5'd18;
  localparam logic [4:0] OP_DIV_S     = 5'd19;

  localparam logic signed [15:0] MAX16 = 16'sh7fff;
  localparam logic signed [15:0] MIN16 = 16'sh8000;
  localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;

  // quotient bits resolved in each pipeline stage (three stages, 15 bits)
  localparam int DivStepsPerStage = 5;

  typedef struct packed {
    logic [15:0] rem;
    logic [14:0] quo;
  } div_state_t;

  function automatic div_state_t div_step(div_state_t s, logic [15:0] den);
    logic [16:0] sh;
    div_state_t  n;
    sh = {s.rem, 1'b0};
    if (sh >= {1'b0, den}) begin
      n.rem = 16'(sh - {1'b0, den});
      n.quo = {s.quo[13:0], 1'b1};
    end else begin
      n.rem = sh[15:0];
      n.quo = {s.quo[13:0], 1'b0};
    end
    return n;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [31:0] v);
    if (v > 32'sd32767) return MAX16;
    if (v < -32'sd32768) return MIN16;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return MAX32;
    if (v < -64'sd2147483648) return MIN32;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] shift16(logic signed [15:0] v,
                                                 logic signed [15:0] cnt);
    logic signed [31:0] w;
    logic signed [16:0] m;
    w = 32'(v) <<< cnt[3:0];
    m = -(17'(cnt));
    if (v == 16'sd0 || cnt == 16'sd0) return v;
    if (!cnt[15]) begin
      if (cnt >= 16'sd15) return v[15] ? MIN16 : MAX16;
      return sat16(w);
    end
    if (m >= 17'sd15) return v[15] ? -16'sd1 : 16'sd0;
    return v >>> m[3:0];
  endfunction

  function automatic logic signed [31:0] shift32(logic signed [31:0] v,
                                                 logic signed [15:0] cnt);
    logic signed [63:0] w;
    logic signed [16:0] m;
    w = 64'(v) <<< cnt[4:0];
    m = -(17'(cnt));
    if (v == 32'sd0 || cnt == 16'sd0) return v;
    if (!cnt[15]) begin
      if (cnt >= 16'sd31) return v[31] ? MIN32 : MAX32;
      return sat32(w);
    end
    if (m >= 17'sd31) return v[31] ? -32'sd1 : 32'sd0;
    return v >>> m[4:0];
  endfunction

  // count of redundant sign bits, or zero for a zero input
  function automatic logic [4:0] norm16(logic [15:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd15;
    found = 1'b0;
    if (v == 16'h0000 || v == 16'h8000) return 5'd0;
    for (int i = 14; i >= 0; i--) begin
      if (!found && v[i] != v[15]) begin
        n = 5'(14 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] norm32(logic [31:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd31;
    found = 1'b0;
    if (v == 32'h0000_0000 || v == 32'h8000_0000) return 5'd0;
    for (int i = 30; i >= 0; i--) begin
      if (!found && v[i] != v[31]) begin
        n = 5'(30 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ----- rtl/sfpa_in_if.sv -----
// Operand channel of the saturating fixed-point ALU: valid/ready and item
// payload. Depends on nothing.
interface sfpa_in_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  kind;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic signed [31:0] wide_a;
  logic signed [31:0] wide_b;

  modport source (output valid, kind, x, y, wide_a, wide_b, input ready);
  modport sink   (input valid, kind, x, y, wide_a, wide_b, output ready);
endinterface

// ----- rtl/sfpa_out_if.sv -----
// Result channel of the saturating fixed-point ALU: valid/ready and item
// payload. Depends on nothing.
interface sfpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               bad_operands;

  modport source (output valid, value, bad_operands, input ready);
  modport sink   (input valid, value, bad_operands, output ready);
endinterface

// ----- rtl/saturating_fixed_point_alu_unit.sv -----
// Top level of the saturating fixed-point ALU.
// Depends on sfpa_pkg, sfpa_in_if and sfpa_out_if.

// Speech-codec style fixed-point ALU: each operand item selects one of twenty
// saturating operations by kind and yields exactly one result item. The unit
// is a three-stage pipeline and takes one item per cycle when not stalled; each
// item passes the stage-one, stage-two and output registers. Stage one does the
// 16x16 multiply, all add/shift/extract/normalize work and the first five
// quotient bits of div_s; stage two finishes mult, mult_r and L_mac from the
// registered product and resolves five more quotient bits; stage three, which
// is the output register, resolves the last five quotient bits and picks the
// result. The whole pipe advances when the output register is empty or taken,
// so a stall on the result side holds every stage and nothing is lost or
// repeated. Sixteen-bit results appear sign-extended in value; bad_operands is
// set only for div_s when the numerator is negative, the denominator is not
// positive or the numerator exceeds the denominator. Unused kinds return zero.
module saturating_fixed_point_alu_unit (
  input logic        clk,
  input logic        rst,
  sfpa_in_if.sink    operands,
  sfpa_out_if.source results
);

  logic advance;

  // stage one
  logic                   s1_valid;
  logic                   s1_is_div;
  logic            [4:0]  s1_kind;
  logic                   s1_minmin;
  logic signed     [31:0] s1_prod;
  logic signed     [31:0] s1_acc;
  logic signed     [31:0] s1_misc;
  logic                   s1_bad;
  logic                   s1_eq;
  sfpa_pkg::div_state_t   s1_div;
  logic            [15:0] s1_den;

  // stage two
  logic                   s2_valid;
  logic                   s2_is_div;
  logic signed     [31:0] s2_misc;
  logic                   s2_bad;
  logic                   s2_eq;
  sfpa_pkg::div_state_t   s2_div;
  logic            [15:0] s2_den;

  // stage three is the output register
  logic                   s3_valid;
  logic signed     [31:0] s3_value;
  logic                   s3_bad;

  logic signed     [31:0] s1_misc_next;
  sfpa_pkg::div_state_t   s1_div_next;
  logic signed     [31:0] s2_misc_next;
  sfpa_pkg::div_state_t   s2_div_next;
  sfpa_pkg::div_state_t   s3_div_next;

  logic signed     [15:0] y_neg;
  logic signed     [16:0] sum16;
  logic signed     [16:0] dif16;
  logic signed     [15:0] sh16;
  logic signed     [31:0] sh32;
  logic signed     [32:0] rnd;
  logic signed     [31:0] dbl;

  // hold the whole pipe while the result waits
  assign advance        = !s3_valid || results.ready;
  assign operands.ready = advance;

  assign results.valid        = s3_valid;
  assign results.value        = s3_value;
  assign results.bad_operands = s3_bad;

  // stage one: everything that needs no product
  always_comb begin
    y_neg = -operands.y;
    sum16 = 17'(operands.x) + 17'(operands.y);
    dif16 = 17'(operands.x) - 17'(operands.y);
    sh16  = sfpa_pkg::shift16(operands.x,
                              (operands.kind == sfpa_pkg::OP_SHR) ? y_neg : operands.y);
    sh32  = sfpa_pkg::shift32(operands.wide_a,
                              (operands.kind == sfpa_pkg::OP_L_SHR) ? y_neg : operands.y);
    case (operands.kind)
      sfpa_pkg::OP_ADD:       s1_misc_next = 32'(sfpa_pkg::sat16(32'(sum16)));
      sfpa_pkg::OP_SUB:       s1_misc_next = 32'(sfpa_pkg::sat16(32'(dif16)));
      sfpa_pkg::OP_ABS: begin
        if (operands.x == sfpa_pkg::MIN16) s1_misc_next = 32'(sfpa_pkg::MAX16);
        else if (operands.x[15]) s1_misc_next = -32'(operands.x);
        else s1_misc_next = 32'(operands.x);
      end
      sfpa_pkg::OP_NEGATE: begin
        if (operands.x == sfpa_pkg::MIN16) s1_misc_next = 32'(sfpa_pkg::MAX16);
        else s1_misc_next = -32'(operands.x);
      end
      sfpa_pkg::OP_SHL,
      sfpa_pkg::OP_SHR:       s1_misc_next = 32'(sh16);
      sfpa_pkg::OP_EXTRACT_H: s1_misc_next = operands.wide_a >>> 16;
      sfpa_pkg::OP_EXTRACT_L: s1_misc_next = 32'($signed(operands.wide_a[15:0]));
      sfpa_pkg::OP_DEPOSIT_H: s1_misc_next = {operands.x, 16'h0000};
      sfpa_pkg::OP_DEPOSIT_L: s1_misc_next = 32'(operands.x);
      sfpa_pkg::OP_L_ADD:
        s1_misc_next = sfpa_pkg::sat32(64'(operands.wide_a) + 64'(operands.wide_b));
      sfpa_pkg::OP_L_SUB:
        s1_misc_next = sfpa_pkg::sat32(64'(operands.wide_a) - 64'(operands.wide_b));
      sfpa_pkg::OP_L_SHL,
      sfpa_pkg::OP_L_SHR:     s1_misc_next = sh32;
      sfpa_pkg::OP_NORM_S:    s1_misc_next = {27'd0, sfpa_pkg::norm16(operands.x)};
      sfpa_pkg::OP_NORM_L:    s1_misc_next = {27'd0, sfpa_pkg::norm32(operands.wide_a)};
      default:                s1_misc_next = 32'sd0;
    endcase

    // first quotient bits: remainder starts at the numerator
    s1_div_next.rem = operands.x;
    s1_div_next.quo = '0;
    for (int i = 0; i < sfpa_pkg::DivStepsPerStage; i++) begin
      s1_div_next = sfpa_pkg::div_step(s1_div_next, operands.y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= operands.valid;
    end
    if (advance) begin
      s1_kind   <= operands.kind;
      s1_is_div <= (operands.kind == sfpa_pkg::OP_DIV_S);
      s1_minmin <= (operands.x == sfpa_pkg::MIN16) && (operands.y == sfpa_pkg::MIN16);
      s1_prod   <= 32'(operands.x) * 32'(operands.y);
      s1_acc    <= operands.wide_a;
      s1_misc   <= s1_misc_next;
      s1_bad    <= operands.x[15] || operands.y[15] || (operands.y == 16'sd0) ||
                   (operands.x > operands.y);
      s1_eq     <= (operands.x == operands.y);
      s1_div    <= s1_div_next;
      s1_den    <= operands.y;
    end
  end

  // stage two: finish the product-based operations
  always_comb begin
    rnd = 33'(s1_prod) + 33'sd16384;
    dbl = s1_prod <<< 1;
    case (s1_kind)
      sfpa_pkg::OP_MULT: begin
        if (s1_minmin) s2_misc_next = 32'(sfpa_pkg::MAX16);
        else s2_misc_next = s1_prod >>> 15;
      end
      sfpa_pkg::OP_MULT_R: begin
        if (s1_minmin) s2_misc_next = 32'(sfpa_pkg::MAX16);
        else s2_misc_next = 32'(rnd >>> 15);
      end
      sfpa_pkg::OP_L_MAC:
        s2_misc_next = sfpa_pkg::sat32(64'(s1_acc) + 64'(dbl));
      default: s2_misc_next = s1_misc;
    endcase

    s2_div_next = s1_div;
    for (int i = 0; i < sfpa_pkg::DivStepsPerStage; i++) begin
      s2_div_next = sfpa_pkg::div_step(s2_div_next, s1_den);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
    if (advance) begin
      s2_is_div <= s1_is_div;
      s2_misc   <= s2_misc_next;
      s2_bad    <= s1_bad;
      s2_eq     <= s1_eq;
      s2_div    <= s2_div_next;
      s2_den    <= s1_den;
    end
  end

  // stage three: last quotient bits and result select
  always_comb begin
    s3_div_next = s2_div;
    for (int i = 0; i < sfpa_pkg::DivStepsPerStage; i++) begin
      s3_div_next = sfpa_pkg::div_step(s3_div_next, s2_den);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
    if (advance) begin
      if (!s2_is_div) s3_value <= s2_misc;
      else if (s2_bad) s3_value <= 32'sd0;
      else if (s2_eq) s3_value <= 32'(sfpa_pkg::MAX16);
      else s3_value <= {17'd0, s3_div_next.quo};
      s3_bad <= s2_is_div && s2_bad;
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for the saturating fixed-point ALU unit: directed table
// then random operations, checked against an in-bench operator model.
// Depends on sfpa_pkg, sfpa_in_if, sfpa_out_if and the unit's RTL.
module testbench;
  import sfpa_pkg::*;

  typedef struct {
    logic [4:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [31:0] wide_a;
    logic signed [31:0] wide_b;
    bit                 known;     // expected result typed in the row
    logic signed [31:0] value;
    logic               bad;
  } op_row_t;

  typedef struct {
    logic signed [31:0] value;
    logic               bad;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 49;
  int error_count = 0;
  alu_result_t pending_results[$];

  sfpa_in_if  operands ();
  sfpa_out_if results ();

  saturating_fixed_point_alu_unit dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands.sink),
    .results  (results.source)
  );

  always #2 clk = ~clk;

  // Saturating helpers kept in 64-bit signed arithmetic.
  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Bidirectional saturating shift; lim is 15 for words, 31 for longs.
  function automatic longint sat_shift(longint v, longint cnt, int lim);
    if (v == 0 || cnt == 0) return v;
    if (cnt > 0) begin
      if (cnt >= lim) return (v < 0) ? -(64'sd1 <<< lim) : (64'sd1 <<< lim) - 1;
      return (lim == 15) ? clamp16(v * (64'sd1 <<< cnt)) : clamp32(v * (64'sd1 <<< cnt));
    end
    if (-cnt >= lim) return (v < 0) ? -1 : 0;
    return v >>> (-cnt);
  endfunction

  // Left shifts needed to bring v into the normalized band.
  function automatic longint lead_shifts(longint v, longint half);
    longint n;
    n = 0;
    if (v == 0 || v == -2 * half) return 0;
    if (v < 0) begin
      while (v >= -half) begin v = v * 2; n++; end
    end else begin
      while (v < half) begin v = v * 2; n++; end
    end
    return n;
  endfunction

  function automatic alu_result_t compute_alu(op_row_t op);
    alu_result_t res;
    longint xv, yv, av, bv, r, neg_y;
    xv = op.x; yv = op.y; av = op.wide_a; bv = op.wide_b;
    neg_y = longint'($signed(16'(-op.y)));
    r = 0;
    res.bad = 1'b0;
    case (op.kind)
      OP_ADD:       r = clamp16(xv + yv);
      OP_SUB:       r = clamp16(xv - yv);
      OP_MULT:      r = (xv == -32768 && yv == -32768) ? 32767 : (xv * yv) >>> 15;
      OP_MULT_R:    r = (xv == -32768 && yv == -32768) ? 32767 : (xv * yv + 16384) >>> 15;
      OP_ABS:       r = (xv == -32768) ? 32767 : ((xv < 0) ? -xv : xv);
      OP_NEGATE:    r = (xv == -32768) ? 32767 : -xv;
      OP_SHL:       r = sat_shift(xv, yv, 15);
      OP_SHR:       r = sat_shift(xv, neg_y, 15);
      OP_EXTRACT_H: r = av >>> 16;
      OP_EXTRACT_L: r = longint'(op.wide_a[15:0] ^ 16'h8000) - 32768;
      OP_DEPOSIT_H: r = longint'($signed(32'(xv * 65536)));
      OP_DEPOSIT_L: r = xv;
      OP_L_ADD:     r = clamp32(av + bv);
      OP_L_SUB:     r = clamp32(av - bv);
      OP_L_MAC:     r = clamp32(av + longint'($signed(32'(xv * yv * 2))));
      OP_L_SHL:     r = sat_shift(av, yv, 31);
      OP_L_SHR:     r = sat_shift(av, neg_y, 31);
      OP_NORM_S:    r = lead_shifts(xv, 16384);
      OP_NORM_L:    r = lead_shifts(av, 64'sd1073741824);
      OP_DIV_S: begin
        if (xv < 0 || yv <= 0 || xv > yv) res.bad = 1'b1;
        else if (xv == yv) r = 32767;
        else r = (xv * 32768) / yv;
      end
      default:      r = 0;
    endcase
    res.value = r[31:0];
    return res;
  endfunction

  function automatic op_row_t row(logic [4:0] k, int x, int y, int a, int b,
                                  bit known = 0, int v = 0, bit bad = 0);
    op_row_t t;
    t.kind = k; t.x = x[15:0]; t.y = y[15:0]; t.wide_a = a; t.wide_b = b;
    t.known = known; t.value = v; t.bad = bad;
    return t;
  endfunction

  op_row_t directed[$];

  initial begin
    // Extremes and special cases; values typed in where they are obvious.
    directed.push_back(row(OP_ADD, 32767, 1, 0, 0, 1, 32767));
    directed.push_back(row(OP_SUB, -32768, 1, 0, 0, 1, -32768));
    directed.push_back(row(OP_MULT, -32768, -32768, 0, 0, 1, 32767));
    directed.push_back(row(OP_MULT_R, -32768, -32768, 0, 0, 1, 32767));
    directed.push_back(row(OP_MULT_R, 12345, -777, 0, 0));
    directed.push_back(row(OP_ABS, -32768, 0, 0, 0, 1, 32767));
    directed.push_back(row(OP_NEGATE, -32768, 0, 0, 0, 1, 32767));
    directed.push_back(row(OP_SHL, 1, 15, 0, 0, 1, 32767));
    directed.push_back(row(OP_SHL, -5, 3, 0, 0));
    directed.push_back(row(OP_SHR, -3, -32768, 0, 0, 1, -1));
    directed.push_back(row(OP_SHR, 1000, 20, 0, 0, 1, 0));
    directed.push_back(row(OP_EXTRACT_H, 0, 0, 32'h8000_0000, 0, 1, -32768));
    directed.push_back(row(OP_EXTRACT_L, 0, 0, 32'h1234_ffff, 0, 1, -1));
    directed.push_back(row(OP_DEPOSIT_H, -32768, 0, 0, 0, 1, 32'h8000_0000));
    directed.push_back(row(OP_DEPOSIT_L, -32768, 0, 0, 0, 1, -32768));
    directed.push_back(row(OP_L_ADD, 0, 0, 32'h7fff_ffff, 1, 1, 32'h7fff_ffff));
    directed.push_back(row(OP_L_SUB, 0, 0, 32'h8000_0000, 1, 1, 32'h8000_0000));
    directed.push_back(row(OP_L_MAC, -32768, -32768, 0, 0, 1, 32'h8000_0000));
    directed.push_back(row(OP_L_SHL, 0, 31, -7, 0, 1, 32'h8000_0000));
    directed.push_back(row(OP_L_SHR, 0, 40, 32'h8000_0000, 0, 1, -1));
    directed.push_back(row(OP_NORM_S, -32768, 0, 0, 0, 1, 0));
    directed.push_back(row(OP_NORM_L, 0, 0, 1, 0, 1, 30));
    directed.push_back(row(OP_DIV_S, 5, 5, 0, 0, 1, 32767));
    directed.push_back(row(OP_DIV_S, -1, 5, 0, 0, 1, 0, 1));
    directed.push_back(row(OP_DIV_S, 3, 0, 0, 0, 1, 0, 1));
    directed.push_back(row(5'd31, 1, 1, 1, 1, 1, 0, 0));
  end

  // Cycle limit: ~800 items, each at worst a long stall; generous margin.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: randomly drop ready at the configured rate.
  always @(posedge clk) begin
    if (rst) results.ready <= 1'b0;
    else results.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    alu_result_t want;
    if (!rst && results.valid && results.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result value=%0d", results.value);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (results.value !== want.value) begin
          $error("value expected %0d actual %0d", want.value, results.value);
          error_count++;
        end
        if (results.bad_operands !== want.bad) begin
          $error("bad_operands expected %0b actual %0b", want.bad,
                 results.bad_operands);
          error_count++;
        end
      end
    end
  end

  // Random operand item; div_s is biased toward valid fractions.
  function automatic op_row_t random_op();
    op_row_t t;
    int unsigned sel;
    t = row(5'($urandom_range(20) == 20 ? $urandom_range(31, 20) : $urandom_range(19)),
            0, 0, 0, 0);
    sel = $urandom_range(7);
    t.x = (sel == 0) ? 16'h8000 : (sel == 1) ? 16'h7fff : 16'($urandom);
    sel = $urandom_range(7);
    t.y = (sel == 0) ? 16'h8000 : (sel < 3) ? 16'(int'($urandom_range(40)) - 20)
        : 16'($urandom);
    sel = $urandom_range(7);
    t.wide_a = (sel == 0) ? 32'h8000_0000 : (sel == 1) ? 32'($urandom_range(1000))
             : $urandom;
    t.wide_b = $urandom;
    if (t.kind == OP_DIV_S && $urandom_range(3) != 0) begin
      t.y = 16'($urandom_range(32767, 1));
      t.x = 16'($urandom_range(int'(t.y)));
    end
    return t;
  endfunction

  // Present one item, hold until accepted, then record its expectation.
  task automatic send_op(op_row_t t);
    alu_result_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      operands.valid <= 1'b0;
      @(posedge clk);
    end
    operands.valid  <= 1'b1;
    operands.kind   <= t.kind;
    operands.x      <= t.x;
    operands.y      <= t.y;
    operands.wide_a <= t.wide_a;
    operands.wide_b <= t.wide_b;
    e = compute_alu(t);
    if (t.known) begin
      e.value = t.value;
      e.bad = t.bad;
    end
    do @(posedge clk); while (!operands.ready);
    pending_results.push_back(e);
  endtask

  initial begin
    operands.valid <= 1'b0;
    operands.kind <= '0; operands.x <= '0; operands.y <= '0;
    operands.wide_a <= '0; operands.wide_b <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_op(directed[i]);
    operands.valid <= 1'b0;
    // Hold off until the pipe has drained.
    while (pending_results.size() != 0) @(posedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 49 : 0;
      recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 6 : 0;
      for (int n = 0; n < 250; n++) send_op(random_op());
    end
    operands.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
